// ===== design/piecewise_aggregate_approximation_core_assert.svh =====
// Assertion macros for the piecewise aggregate approximation core.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef PIECEWISE_AGGREGATE_APPROXIMATION_CORE_ASSERT_SVH
`define PIECEWISE_AGGREGATE_APPROXIMATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every edge outside reset
`define PWAA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check a property on every edge, reset included
`define PWAA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PWAA_ASSERT(label, prop, msg)
`define PWAA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== design/pwaa_pkg.sv =====
// Shared widths, register indexes and types of the PAA core.
// No dependencies.
package pwaa_pkg;

  localparam int unsigned CFG_W    = 13;  // config register width
  localparam int unsigned SAMPLE_W = 16;  // sample and coefficient width
  localparam int unsigned SUM_W    = SAMPLE_W + CFG_W + 1;  // weighted sum
  localparam int unsigned QUO_W    = SAMPLE_W;  // quotient magnitude bits
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH    = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;

  // one job from front to back: a segment sum to divide or a sample to pass
  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic                    last;
    logic                    pass;
  } pwaa_job_t;

  typedef struct packed {
    logic at_last;    // next sample closes the row
    logic row_start;  // row position is zero
    logic fill_lt_n;  // open segment below one segment span
  } pwaa_front_stat_t;

  typedef struct packed {
    logic busy;       // divider holds a job
  } pwaa_back_stat_t;

endpackage

// ===== design/pwaa_queue.sv =====
// Small FIFO of jobs between the PAA front and back ends.
// Depends on pwaa_pkg.
module pwaa_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pwaa_pkg::pwaa_job_t wdata_i,
  input  logic                pop_i,
  output pwaa_pkg::pwaa_job_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);
  import pwaa_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pwaa_job_t        mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/pwaa_front.sv =====
// PAA front end: takes samples, weights them into the open segment and
// queues finished segment sums or pass-through samples. Depends on pwaa_pkg.
module pwaa_front #(
  parameter int unsigned IDX_W = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic [pwaa_pkg::CFG_W-1:0]       n_i,
  input  logic [pwaa_pkg::CFG_W-1:0]       s_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [pwaa_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output pwaa_pkg::pwaa_job_t              q_data_o,
  output pwaa_pkg::pwaa_front_stat_t       stat_o
);
  import pwaa_pkg::*;

  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [CFG_W-1:0]        fill_q, fill_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  logic                    accept, last, pass, seg_done;
  logic [IDX_W:0]          idx_inc;
  logic [CFG_W:0]          fill_plus;
  logic [CFG_W-1:0]        part, rest;
  logic signed [SUM_W-1:0] x_ext, part_ext, s_ext;
  logic signed [SUM_W-1:0] prod_part, prod_s, total;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // row position and segment boundary
  assign idx_inc   = {1'b0, idx_q} + 1'b1;
  assign last      = (32'(idx_inc) >= 32'(n_i));
  assign pass      = (n_i <= s_i);
  assign fill_plus = {1'b0, fill_q} + {1'b0, s_i};
  assign seg_done  = (fill_plus >= {1'b0, n_i});
  assign part      = n_i - fill_q;
  assign rest      = s_i - part;

  // weighting: sample times the units it gives to each side
  assign x_ext     = SUM_W'(sample_i);
  assign part_ext  = $signed({{(SUM_W - CFG_W){1'b0}}, part});
  assign s_ext     = $signed({{(SUM_W - CFG_W){1'b0}}, s_i});
  assign prod_part = x_ext * part_ext;
  assign prod_s    = x_ext * s_ext;
  assign total     = sum_q + prod_part;

  // queued job
  assign q_push_o       = accept && (pass || seg_done);
  assign q_data_o.value = pass ? x_ext : total;
  assign q_data_o.last  = last;
  assign q_data_o.pass  = pass;

  always_comb begin
    idx_d  = idx_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (clear_i) begin
      idx_d  = '0;
      fill_d = '0;
      sum_d  = '0;
    end else if (accept) begin
      if (!pass) begin
        if (seg_done) begin
          fill_d = rest;
          sum_d  = prod_s - prod_part;
        end else begin
          fill_d = fill_plus[CFG_W-1:0];
          sum_d  = sum_q + prod_s;
        end
      end
      if (last) begin
        idx_d  = '0;
        fill_d = '0;
        sum_d  = '0;
      end else begin
        idx_d = idx_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  assign stat_o.at_last   = last;
  assign stat_o.row_start = (idx_q == '0);
  assign stat_o.fill_lt_n = (fill_q < n_i);

endmodule

// ===== design/pwaa_back.sv =====
// PAA back end: restoring divider, one quotient bit a cycle, and the
// output register. Depends on pwaa_pkg.
module pwaa_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [pwaa_pkg::CFG_W-1:0]           n_i,
  input  logic                                 q_empty_i,
  input  pwaa_pkg::pwaa_job_t                  q_data_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pwaa_pkg::SAMPLE_W-1:0] coefficient_o,
  output logic                                 last_of_row_o,
  output pwaa_pkg::pwaa_back_stat_t            stat_o
);
  import pwaa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic [1:0]              state_q, state_d;
  logic [STEP_W-1:0]       cnt_q, cnt_d;
  logic [CFG_W-1:0]        rem_q, rem_d;
  logic [QUO_W-1:0]        dq_q, dq_d;
  logic                    neg_q, neg_d;
  logic                    last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] coef_q, coef_d;
  logic                    out_last_q, out_last_d;

  logic                    out_free, load_out;
  logic [SUM_W-2:0]        mag;
  logic signed [SUM_W-1:0] neg_value;
  logic [CFG_W:0]          r2;
  logic                    ge;
  logic [QUO_W-1:0]        quo;

  assign out_free = !out_valid_q || !out_stall_i;

  // magnitude of the segment sum; it stays below 2**(SUM_W-2)
  assign neg_value = -q_data_i.value;
  assign mag = q_data_i.value[SUM_W-1] ? neg_value[SUM_W-2:0]
                                       : q_data_i.value[SUM_W-2:0];

  // one restoring step
  assign r2  = {rem_q, dq_q[QUO_W-1]};
  assign ge  = (r2 >= {1'b0, n_i});
  assign quo = neg_q ? (~dq_q + 1'b1) : dq_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    neg_d       = neg_q;
    last_d      = last_q;
    q_pop_o     = 1'b0;
    load_out    = 1'b0;
    coef_d      = coef_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.pass) begin
            if (out_free) begin
              q_pop_o    = 1'b1;
              load_out   = 1'b1;
              coef_d     = q_data_i.value[SAMPLE_W-1:0];
              out_last_d = q_data_i.last;
            end
          end else begin
            q_pop_o = 1'b1;
            rem_d   = CFG_W'(mag >> QUO_W);
            dq_d    = mag[QUO_W-1:0];
            neg_d   = q_data_i.value[SUM_W-1];
            last_d  = q_data_i.last;
            cnt_d   = '1;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = ge ? CFG_W'(r2 - {1'b0, n_i}) : r2[CFG_W-1:0];
        dq_d  = {dq_q[QUO_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          coef_d     = quo;
          out_last_d = last_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // divider and output payload
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dq_q       <= dq_d;
    neg_q      <= neg_d;
    last_q     <= last_d;
    coef_q     <= coef_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign last_of_row_o = out_last_q;
  assign stat_o.busy   = (state_q != ST_IDLE);

endmodule

// ===== design/piecewise_aggregate_approximation_core.sv =====
// A pass-through sample goes through the job queue and the output register; a
// segment average goes through the job queue, the divider and the output register.
// One sample per cycle into the front end while the job queue is not full; the back
// end takes a new segment only once the last has left its one-bit-per-cycle divider.
// Reset: row_length 1024, segment_count 64, row state and job queue empty.
`include "piecewise_aggregate_approximation_core_assert.svh"
module piecewise_aggregate_approximation_core #(
  parameter int unsigned MAX_ROW = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pwaa_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [pwaa_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pwaa_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pwaa_pkg::SAMPLE_W-1:0] coefficient_o,
  output logic                                 last_of_row_o
);
  import pwaa_pkg::*;

  localparam int unsigned IDX_W     = $clog2(MAX_ROW);
  localparam int unsigned CFG_MAX   = (1 << CFG_W) - 1;
  localparam int unsigned CLAMP_TOP = (MAX_ROW > CFG_MAX) ? CFG_MAX : MAX_ROW;

  logic [CFG_W-1:0]  row_length_q, segment_count_q;
  logic [CFG_W-1:0]  n_eff, s_eff;
  logic              q_push, q_pop, q_full, q_empty;
  pwaa_job_t         q_wdata, q_rdata;
  pwaa_front_stat_t  fr_stat;
  pwaa_back_stat_t   bk_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q    <= CFG_W'(1024);
      segment_count_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_LENGTH:    row_length_q    <= cfg_wdata_i;
        REG_SEGMENT_COUNT: segment_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero reads as one, large values saturate at the row limit
  assign n_eff = (row_length_q == '0) ? CFG_W'(1) :
                 (32'(row_length_q) > CLAMP_TOP) ? CFG_W'(CLAMP_TOP) : row_length_q;
  assign s_eff = (segment_count_q == '0) ? CFG_W'(1) :
                 (32'(segment_count_q) > CLAMP_TOP) ? CFG_W'(CLAMP_TOP) : segment_count_q;

  pwaa_front #(
    .IDX_W (IDX_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we_i),
    .n_i        (n_eff),
    .s_i        (s_eff),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .stat_o     (fr_stat)
  );

  pwaa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pwaa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n_eff),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .coefficient_o (coefficient_o),
    .last_of_row_o (last_of_row_o),
    .stat_o        (bk_stat)
  );

  // checks
  `PWAA_ASSERT(a_queue_no_overflow, q_push |-> !q_full, "job pushed into full queue")
  `PWAA_ASSERT(a_last_restarts_row, (in_valid_i && !in_stall_o && fr_stat.at_last) |=> fr_stat.row_start, "row did not restart after its last sample")
  `PWAA_ASSERT(a_fill_below_span, fr_stat.fill_lt_n, "open segment reached a full span")
  `PWAA_ASSERT_ALWAYS(a_no_pop_while_busy, bk_stat.busy |-> !q_pop, "queue popped while divider busy")

endmodule
